@@ rtl/char_bigram_count_and_score_unit_assert.svh @@
// assertion macros shared by the bigram unit modules
// expects clk and arst_n in the scope of use
`ifndef CHAR_BIGRAM_COUNT_AND_SCORE_UNIT_ASSERT_SVH
`define CHAR_BIGRAM_COUNT_AND_SCORE_UNIT_ASSERT_SVH

// same-cycle implication
`define CBS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBS_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// condition that must never hold
`define CBS_ASSERT_NEVER(lbl, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/cbs_pkg.sv @@
// shared constants, types and helpers of the bigram count and score unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

	localparam int ALPHABET    = 95;
	localparam int COUNT_WIDTH = 16;
	localparam int TABLE_DEPTH = ALPHABET * ALPHABET;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = 7;
	localparam int TALLY_W     = 16;
	localparam int TOTAL_W     = 32;
	localparam int MEAN_W      = 19;
	localparam int MEAN_MAX    = 262140;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int SET_LOW_W   = 64;
	localparam int SET_HIGH_W  = 31;
	localparam int MODE_W      = 6;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [TALLY_W-1:0]     TALLY_MAX = {TALLY_W{1'b1}};
	localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic [SET_LOW_W-1:0]  ALNUM_LOW_RST  = 64'd576460743780532224;
	localparam logic [SET_LOW_W-1:0]  ALPHA_LOW_RST  = 64'd576460743713488896;
	localparam logic [SET_HIGH_W-1:0] ALPHA_HIGH_RST = 31'd134217726;
	localparam logic [MODE_W-1:0]     MODE_RST       = 6'd7;

	localparam logic [7:0] CHAR_MIN  = 8'h20;
	localparam logic [7:0] CHAR_MAX  = 8'h7E;
	localparam logic [7:0] CHAR_HIGH = 8'h60;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SCORE  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_NICK = 2'd0,
		KIND_USER = 2'd1,
		KIND_INFO = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NICK_LOW  = 3'd0,
		CFG_NICK_HIGH = 3'd1,
		CFG_USER_LOW  = 3'd2,
		CFG_USER_HIGH = 3'd3,
		CFG_INFO_LOW  = 3'd4,
		CFG_INFO_HIGH = 3'd5,
		CFG_MODE      = 3'd6
	} cfg_idx_t;

	// one queued table operation
	typedef struct packed {
		logic               is_load;
		logic               is_add;
		logic               has_pair;
		logic               fold;
		logic               has_result;
		logic               clear_total;
		logic [IDX_W-1:0]   prev_idx;
		logic [IDX_W-1:0]   cur_idx;
		logic [TALLY_W-1:0] tally;
	} op_t;

	// letter index to upper-case index
	function automatic logic [IDX_W-1:0] up_idx(input logic [IDX_W-1:0] i);
		if (i >= 7'd65 && i <= 7'd90) begin
			return i - 7'd32;
		end
		return i;
	endfunction

	// letter index to lower-case index
	function automatic logic [IDX_W-1:0] lo_idx(input logic [IDX_W-1:0] i);
		if (i >= 7'd33 && i <= 7'd58) begin
			return i + 7'd32;
		end
		return i;
	endfunction

	function automatic logic [ADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		return ADDR_W'(ADDR_W'(a) * ADDR_W'(ALPHABET)) + ADDR_W'(b);
	endfunction

endpackage

`default_nettype wire

@@ rtl/cbs_front.sv @@
// front end: config registers, byte classification, pair tracking
// depends on cbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module cbs_front import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [1:0]            action,
	input  wire logic [1:0]            field_kind,
	input  wire logic [7:0]            char_code,
	input  wire logic                  last_char,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                       push,
	output op_t                        push_op
);

	logic [SET_LOW_W-1:0]  nick_low_q, user_low_q, info_low_q;
	logic [SET_HIGH_W-1:0] nick_high_q, user_high_q, info_high_q;
	logic [MODE_W-1:0]     mode_q;
	logic [IDX_W-1:0]      prev_q;
	logic                  prev_valid_q;
	logic [TALLY_W-1:0]    tally_q;

	logic [SET_LOW_W-1:0]  set_low;
	logic [SET_HIGH_W:0]   set_high;
	logic                  fold, adjacent, printable, ins, pair;
	logic [7:0]            off_low, off_high;
	logic [IDX_W-1:0]      cur;
	logic [IDX_W-1:0]      prev_d;
	logic                  prev_valid_d;
	logic [TALLY_W-1:0]    tally_d;

	always_comb begin
		set_low  = '0;
		set_high = '0;
		fold     = 1'b0;
		adjacent = 1'b0;
		case (field_kind)
			KIND_NICK: begin
				set_low  = nick_low_q;
				set_high = {1'b0, nick_high_q};
				fold     = mode_q[0];
				adjacent = mode_q[3];
			end
			KIND_USER: begin
				set_low  = user_low_q;
				set_high = {1'b0, user_high_q};
				fold     = mode_q[1];
				adjacent = mode_q[4];
			end
			KIND_INFO: begin
				set_low  = info_low_q;
				set_high = {1'b0, info_high_q};
				fold     = mode_q[2];
				adjacent = mode_q[5];
			end
			default: ;
		endcase
	end

	assign printable = (char_code >= CHAR_MIN) && (char_code <= CHAR_MAX);
	assign off_low   = char_code - CHAR_MIN;
	assign off_high  = char_code - CHAR_HIGH;
	assign cur       = off_low[IDX_W-1:0];
	assign ins       = printable && ((char_code < CHAR_HIGH) ? set_low[off_low[5:0]]
		: set_high[off_high[4:0]]);

	always_comb begin
		pair         = 1'b0;
		prev_d       = prev_q;
		prev_valid_d = prev_valid_q;
		tally_d      = tally_q;
		case (action)
			ACT_ADD, ACT_REMOVE: begin
				if (printable) begin
					pair         = prev_valid_q;
					prev_d       = cur;
					prev_valid_d = 1'b1;
				end else if (char_code > CHAR_MAX) begin
					prev_valid_d = 1'b0;
				end
			end
			ACT_SCORE: begin
				if (ins) begin
					pair         = prev_valid_q && (tally_q != TALLY_MAX);
					prev_d       = cur;
					prev_valid_d = 1'b1;
					if (pair) begin
						tally_d = tally_q + 1'b1;
					end
				end else if (adjacent) begin
					prev_valid_d = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		push_op.is_load     = (action == ACT_ADD) || (action == ACT_REMOVE);
		push_op.is_add      = (action == ACT_ADD);
		push_op.has_pair    = pair;
		push_op.fold        = fold;
		push_op.has_result  = (action == ACT_SCORE) && last_char;
		push_op.clear_total = last_char;
		push_op.prev_idx    = prev_q;
		push_op.cur_idx     = cur;
		push_op.tally       = tally_d;
		push                = accept && (pair || last_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			tally_q      <= '0;
		end else if (accept) begin
			if (last_char) begin
				prev_q       <= '0;
				prev_valid_q <= 1'b0;
				tally_q      <= '0;
			end else begin
				prev_q       <= prev_d;
				prev_valid_q <= prev_valid_d;
				tally_q      <= tally_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nick_low_q  <= ALNUM_LOW_RST;
			user_low_q  <= ALNUM_LOW_RST;
			info_low_q  <= ALPHA_LOW_RST;
			nick_high_q <= ALPHA_HIGH_RST;
			user_high_q <= ALPHA_HIGH_RST;
			info_high_q <= ALPHA_HIGH_RST;
			mode_q      <= MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NICK_LOW:  nick_low_q  <= cfg_wdata;
				CFG_NICK_HIGH: nick_high_q <= cfg_wdata[SET_HIGH_W-1:0];
				CFG_USER_LOW:  user_low_q  <= cfg_wdata;
				CFG_USER_HIGH: user_high_q <= cfg_wdata[SET_HIGH_W-1:0];
				CFG_INFO_LOW:  info_low_q  <= cfg_wdata;
				CFG_INFO_HIGH: info_high_q <= cfg_wdata[SET_HIGH_W-1:0];
				CFG_MODE:      mode_q      <= cfg_wdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/cbs_queue.sv @@
// short operation queue between front and back end
// depends on cbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "char_bigram_count_and_score_unit_assert.svh"

module cbs_queue import cbs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	input  wire logic pop,
	output op_t       head,
	output logic      full,
	output logic      empty
);

	op_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CBS_ASSERT_NEVER(a_no_overflow, push && full && !pop, "queue overflow")
	`CBS_ASSERT_NEVER(a_no_underflow, pop && empty, "queue underflow")
	`CBS_ASSERT_NEVER(a_count_range, count_q > QCNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

@@ rtl/cbs_back.sv @@
// back end: pair table memory, read-modify-write, score sum and divider
// depends on cbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "char_bigram_count_and_score_unit_assert.svh"

module cbs_back import cbs_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         empty,
	input  wire op_t          head,
	output logic              pop,
	output logic              clearing,
	output logic              done,
	output logic [MEAN_W-1:0] mean
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_ACC   = 8'b0000_1000,
		S_WR    = 8'b0001_0000,
		S_FIN   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	op_t                    op_q;
	logic [3:0]             mask_q;
	logic [ADDR_W-1:0]      addr_q, clr_addr_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [TALLY_W-1:0]     rem_q;
	logic [TOTAL_W-1:0]     dvd_q;
	logic [4:0]             div_cnt_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [COUNT_WIDTH-1:0] table_q [TABLE_DEPTH];

	logic [IDX_W-1:0]       u1, l1, u2, l2, ra, rb;
	logic [3:0]             head_mask, mask_nx;
	logic [ADDR_W-1:0]      rd_addr, wr_addr;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data, upd;
	logic [TOTAL_W:0]       sum;
	logic [TALLY_W:0]       rem_sh;
	logic                   ge;
	logic [TALLY_W-1:0]     rem_nx;
	logic [TOTAL_W-1:0]     quo_nx;

	// fold slots for the queue head
	always_comb begin
		logic [IDX_W-1:0] hu1, hl1, hu2, hl2;
		hu1 = up_idx(head.prev_idx);
		hl1 = lo_idx(head.prev_idx);
		hu2 = up_idx(head.cur_idx);
		hl2 = lo_idx(head.cur_idx);
		head_mask[0] = 1'b1;
		head_mask[1] = head.fold && !head.is_load && (hl1 != hu1);
		head_mask[2] = head.fold && !head.is_load && (hl1 != hu1) && (hl2 != hu2);
		head_mask[3] = head.fold && !head.is_load && (hl2 != hu2);
	end

	assign u1 = up_idx(op_q.prev_idx);
	assign l1 = lo_idx(op_q.prev_idx);
	assign u2 = up_idx(op_q.cur_idx);
	assign l2 = lo_idx(op_q.cur_idx);

	// lowest pending slot picks the entry to read
	always_comb begin
		ra      = op_q.prev_idx;
		rb      = op_q.cur_idx;
		mask_nx = mask_q;
		if (mask_q[0]) begin
			if (op_q.fold && !op_q.is_load) begin
				ra = u1;
				rb = u2;
			end
			mask_nx[0] = 1'b0;
		end else if (mask_q[1]) begin
			ra         = l1;
			rb         = u2;
			mask_nx[1] = 1'b0;
		end else if (mask_q[2]) begin
			ra         = l1;
			rb         = l2;
			mask_nx[2] = 1'b0;
		end else begin
			ra         = u1;
			rb         = l2;
			mask_nx[3] = 1'b0;
		end
		rd_addr = pair_addr(ra, rb);
	end

	always_comb begin
		if (op_q.is_add) begin
			upd = (rd_data_q == COUNT_MAX) ? rd_data_q : rd_data_q + 1'b1;
		end else begin
			upd = (rd_data_q == '0) ? rd_data_q : rd_data_q - 1'b1;
		end
		wr_en   = (state_q == S_CLEAR) || (state_q == S_WR);
		wr_addr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
		wr_data = (state_q == S_CLEAR) ? '0 : upd;
	end

	assign sum    = {1'b0, total_q} + (TOTAL_W + 1)'(rd_data_q);
	assign rem_sh = {rem_q, dvd_q[TOTAL_W-1]};
	assign ge     = rem_sh >= {1'b0, op_q.tally};
	assign rem_nx = ge ? TALLY_W'(rem_sh - {1'b0, op_q.tally}) : rem_sh[TALLY_W-1:0];
	assign quo_nx = {dvd_q[TOTAL_W-2:0], ge};

	assign pop      = (state_q == S_IDLE) && !empty;
	assign clearing = (state_q == S_CLEAR);
	assign done     = (state_q == S_OUT);
	assign mean     = mean_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
		rd_data_q <= table_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q   <= head;
			mask_q <= head_mask;
		end else if (state_q == S_RD) begin
			mask_q <= mask_nx;
			addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			total_q    <= '0;
			rem_q      <= '0;
			dvd_q      <= '0;
			div_cnt_q  <= '0;
			mean_q     <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!empty) begin
						state_q <= head.has_pair ? S_RD : S_FIN;
					end
				end
				S_RD: begin
					state_q <= op_q.is_load ? S_WR : S_ACC;
				end
				S_ACC: begin
					total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
					state_q <= (mask_q != '0) ? S_RD : S_FIN;
				end
				S_WR: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (op_q.has_result) begin
						if (op_q.tally == '0) begin
							mean_q  <= {MEAN_W{1'b1}};
							state_q <= S_OUT;
						end else begin
							rem_q     <= '0;
							dvd_q     <= total_q;
							div_cnt_q <= 5'd31;
							state_q   <= S_DIV;
						end
					end else begin
						if (op_q.clear_total) begin
							total_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					rem_q     <= rem_nx;
					dvd_q     <= quo_nx;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						mean_q  <= (quo_nx > TOTAL_W'(MEAN_MAX)) ? MEAN_W'(MEAN_MAX)
							: quo_nx[MEAN_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					total_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CBS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`CBS_ASSERT_NEXT(a_rd_then_use, state_q == S_RD, state_q == S_ACC || state_q == S_WR,
		"table read not followed by use")
	`CBS_ASSERT_IMPLIES(a_no_pop_clearing, clearing, !pop, "queue popped during clear pass")

endmodule

`default_nettype wire

@@ rtl/char_bigram_count_and_score_unit.sv @@
// top level of the character bigram count and score unit
// depends on cbs_pkg, cbs_front, cbs_queue, cbs_back
//
//  channel   signals                                           direction
//  ------------------------------------------------------------------------
//  command   start, busy, action, field_kind, char_code, last_char   in (busy out)
//  result    done, mean_count                                  out
//  config    cfg_we, cfg_index, cfg_wdata                      in
//
// a byte beat is taken when start is high and busy is low; the front end
// takes one beat per cycle while the four-entry queue has room
// a table update reads and then writes one entry, a scored pair makes one or
// up to four table reads through the single read port, each added to the
// total, and a result adds a shift-subtract divide
// after reset the table is swept to zero, one entry a cycle, all 9025 entries
// with busy high; config writes are taken throughout
// done pulses for one cycle with mean_count; the receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none

module char_bigram_count_and_score_unit import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            action,
	input  wire logic [1:0]            field_kind,
	input  wire logic [7:0]            char_code,
	input  wire logic                  last_char,
	output logic                       done,
	output logic signed [MEAN_W-1:0]   mean_count,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic              accept;
	logic              push, pop, full, empty, clearing;
	op_t               push_op, head;
	logic [MEAN_W-1:0] mean;

	// hold off new beats while the queue is full or the table is swept
	assign busy   = full || clearing;
	assign accept = start && !busy;

	// front end: classify each byte and track the previous usable byte
	cbs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.field_kind(field_kind),
		.char_code (char_code),
		.last_char (last_char),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_op   (push_op)
	);

	// decoupling queue of table operations
	cbs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// back end: table memory, score sum and mean
	cbs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.clearing(clearing),
		.done    (done),
		.mean    (mean)
	);

	assign mean_count = signed'(mean);

endmodule

`default_nettype wire

@@ bench/char_bigram_count_and_score_unit_check.sv @@
// watcher, predictor and scoreboard for the bigram count and score unit
// depends on cbs_pkg; instanced beside the block by the bench top
`timescale 1ns / 1ps
`default_nettype none

module char_bigram_count_and_score_unit_check import cbs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [1:0]            action,
	input  wire logic [1:0]            field_kind,
	input  wire logic [7:0]            char_code,
	input  wire logic                  last_char,
	input  wire logic                  done,
	input  wire logic [MEAN_W-1:0]     mean_count,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         fail_count,
	output int                         means_waiting,
	output int                         beats_seen,
	output int                         means_seen
);

	logic [COUNT_WIDTH-1:0] counts [TABLE_DEPTH];
	logic [IDX_W-1:0]       last_idx;
	logic                   last_ok;
	logic [TOTAL_W-1:0]     run_total;
	logic [TALLY_W-1:0]     run_tally;
	logic [SET_LOW_W-1:0]   set_lo [3];
	logic [SET_HIGH_W-1:0]  set_hi [3];
	logic [MODE_W-1:0]      modes;
	logic [MEAN_W-1:0]      mean_q [$];

	task automatic report(input string what, input logic [MEAN_W-1:0] got,
			input logic [MEAN_W-1:0] want);
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what,
			$signed(got), $signed(want));
		fail_count++;
	endtask

	function automatic bit member(input logic [1:0] k, input logic [7:0] c);
		if (k > 2'd2 || c < CHAR_MIN || c > CHAR_MAX) return 0;
		if (c < CHAR_HIGH) return set_lo[k][c - CHAR_MIN];
		return set_hi[k][c - CHAR_HIGH];
	endfunction

	function automatic logic [IDX_W-1:0] upper(input logic [IDX_W-1:0] i);
		return (i >= 7'd65 && i <= 7'd90) ? i - 7'd32 : i;
	endfunction

	function automatic logic [IDX_W-1:0] lower(input logic [IDX_W-1:0] i);
		return (i >= 7'd33 && i <= 7'd58) ? i + 7'd32 : i;
	endfunction

	function automatic logic [63:0] cnt(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
		return 64'(counts[int'(a) * ALPHABET + int'(b)]);
	endfunction

	// one byte beat through the predictor
	task automatic predict_byte(input logic [1:0] act, input logic [1:0] k,
			input logic [7:0] c, input logic fin);
		logic [IDX_W-1:0] cur, u1, l1, u2, l2;
		logic [63:0] sum;
		int slot;
		bit fold, adj;
		cur = IDX_W'(c - CHAR_MIN);
		if (act == ACT_ADD || act == ACT_REMOVE) begin
			if (c >= CHAR_MIN && c <= CHAR_MAX) begin
				if (last_ok) begin
					slot = int'(last_idx) * ALPHABET + int'(cur);
					if (act == ACT_ADD && counts[slot] != COUNT_MAX) counts[slot]++;
					if (act == ACT_REMOVE && counts[slot] != 0) counts[slot]--;
				end
				last_idx = cur;
				last_ok = 1;
			end else if (c > CHAR_MAX) begin
				last_ok = 0;
			end
		end else if (act == ACT_SCORE) begin
			fold = k <= 2'd2 && modes[k];
			adj = k <= 2'd2 && modes[3 + k];
			if (member(k, c)) begin
				if (last_ok && run_tally != TALLY_MAX) begin
					if (fold) begin
						u1 = upper(last_idx); l1 = lower(last_idx);
						u2 = upper(cur); l2 = lower(cur);
						sum = cnt(u1, u2);
						if (l1 != u1) begin
							sum += cnt(l1, u2);
							if (l2 != u2) sum += cnt(l1, l2);
						end
						if (l2 != u2) sum += cnt(u1, l2);
					end else begin
						sum = cnt(last_idx, cur);
					end
					sum += 64'(run_total);
					run_total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
					run_tally++;
				end
				last_idx = cur;
				last_ok = 1;
			end else if (adj) begin
				last_ok = 0;
			end
			if (fin) begin
				if (run_tally == 0) begin
					mean_q.push_back({MEAN_W{1'b1}});
				end else begin
					sum = 64'(run_total / run_tally);
					if (sum > 64'(MEAN_MAX)) sum = 64'(MEAN_MAX);
					mean_q.push_back(sum[MEAN_W-1:0]);
				end
			end
		end
		if (fin) begin
			last_idx = '0;
			last_ok = 0;
			run_total = '0;
			run_tally = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (counts[i]) counts[i] = '0;
			last_idx = '0;
			last_ok = 0;
			run_total = '0;
			run_tally = '0;
			set_lo[0] = ALNUM_LOW_RST;
			set_lo[1] = ALNUM_LOW_RST;
			set_lo[2] = ALPHA_LOW_RST;
			foreach (set_hi[i]) set_hi[i] = ALPHA_HIGH_RST;
			modes = MODE_RST;
			mean_q.delete();
			fail_count = 0;
			means_waiting = 0;
			beats_seen = 0;
			means_seen = 0;
		end else begin
			// results belong to earlier beats, so check them first
			if (done) begin
				means_seen++;
				if (mean_q.size() == 0) begin
					report("unexpected mean_count", mean_count, '0);
				end else begin
					if (mean_count !== mean_q[0]) report("mean_count", mean_count, mean_q[0]);
					void'(mean_q.pop_front());
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NICK_LOW:  set_lo[0] = cfg_wdata;
					CFG_NICK_HIGH: set_hi[0] = cfg_wdata[SET_HIGH_W-1:0];
					CFG_USER_LOW:  set_lo[1] = cfg_wdata;
					CFG_USER_HIGH: set_hi[1] = cfg_wdata[SET_HIGH_W-1:0];
					CFG_INFO_LOW:  set_lo[2] = cfg_wdata;
					CFG_INFO_HIGH: set_hi[2] = cfg_wdata[SET_HIGH_W-1:0];
					CFG_MODE:      modes = cfg_wdata[MODE_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				beats_seen++;
				predict_byte(action, field_kind, char_code, last_char);
			end
			means_waiting = mean_q.size();
		end
	end

	final begin
		if (mean_q.size() != 0) $display("%0d means never arrived", mean_q.size());
	end

endmodule

`default_nettype wire

@@ bench/char_bigram_count_and_score_unit_test.sv @@
// bench top for the bigram count and score unit: clock, reset, stimulus, verdict
// depends on cbs_pkg, the unit and char_bigram_count_and_score_unit_check
`timescale 1ns / 1ps
`default_nettype none

module char_bigram_count_and_score_unit_test;
	import cbs_pkg::*;

	// codes outside the defined ones, used as noise
	localparam logic [1:0] ACT_NONE  = 2'd3;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int SETTLE = 300;     // cycles the back end may still be busy on loads
	localparam int STALL_LIMIT = 40000;  // covers the table sweep

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] action = '0;
	logic [1:0] field_kind = '0;
	logic [7:0] char_code = '0;
	logic last_char = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic busy, done;
	logic signed [MEAN_W-1:0] mean_count;
	int fail_count, means_waiting, beats_seen, means_seen;
	int stall_cycles = 0;
	int phases_run = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	char_bigram_count_and_score_unit dut (
		.clk, .arst_n, .start, .busy, .action, .field_kind, .char_code, .last_char,
		.done, .mean_count, .cfg_we, .cfg_index, .cfg_wdata
	);

	char_bigram_count_and_score_unit_check checker_i (
		.clk, .arst_n, .start, .busy, .action, .field_kind, .char_code, .last_char,
		.done, .mean_count(mean_count), .cfg_we, .cfg_index, .cfg_wdata,
		.fail_count, .means_waiting, .beats_seen, .means_seen
	);

	// watchdog: any accepted beat, result or register write counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("** char_bigram_count_and_score_unit: FAILED **");
			$finish;
		end
	end

	// present one byte beat and hold it until taken; start stays up afterwards
	// so back-to-back beats need no second assignment in a step
	task automatic put_byte(input logic [1:0] act, input logic [1:0] k,
			input logic [7:0] c, input logic fin);
		bit stalled;
		start <= 1;
		action <= act;
		field_kind <= k;
		char_code <= c;
		last_char <= fin;
		forever begin
			@(negedge clk) stalled = busy;
			@(posedge clk);
			if (!stalled) break;
		end
	endtask

	task automatic pause(input int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// sender bursts: occasionally drop start for a while
	task automatic maybe_gap();
		if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 12));
	endtask

	// registers only change once the block has drained
	task automatic drain();
		pause(1);
		wait (means_waiting == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_all(input logic [63:0] lo0, input logic [30:0] hi0,
			input logic [63:0] lo1, input logic [30:0] hi1, input logic [63:0] lo2,
			input logic [30:0] hi2, input logic [5:0] m);
		drain();
		write_reg(CFG_NICK_LOW, lo0);
		write_reg(CFG_NICK_HIGH, {33'd0, hi0});
		write_reg(CFG_USER_LOW, lo1);
		write_reg(CFG_USER_HIGH, {33'd0, hi1});
		write_reg(CFG_INFO_LOW, lo2);
		write_reg(CFG_INFO_HIGH, {33'd0, hi2});
		write_reg(CFG_MODE, {58'd0, m});
		cfg_we <= 0;
		@(posedge clk);
		phases_run++;
	endtask

	// a small alphabet keeps pairs colliding so counts grow and cancel
	function automatic logic [7:0] word_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'(8'h61 + $urandom_range(0, 3));
			3, 4:    return 8'(8'h41 + $urandom_range(0, 3));
			5:       return 8'(8'h30 + $urandom_range(0, 2));
			6:       return 8'($urandom_range(8'h20, 8'h7E));
			7:       return 8'($urandom_range(8'h00, 8'h1F));
			8:       return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h7F, 8'hFF))
				: 8'(8'h7A - $urandom_range(0, 2));
			default: return 8'(8'h5A - $urandom_range(0, 2));
		endcase
	endfunction

	task automatic put_word(input logic [1:0] act, input logic [1:0] k, input int len,
			inout int sent);
		for (int i = 0; i < len; i++) begin
			put_byte(act, k, word_char(), i == len - 1);
			sent++;
			maybe_gap();
		end
	endtask

	task automatic random_phase(input int quota);
		int sent;
		int pick;
		sent = 0;
		while (sent < quota) begin
			pick = $urandom_range(0, 19);
			if (pick < 9) begin
				put_word(($urandom_range(0, 3) == 0) ? ACT_REMOVE : ACT_ADD,
					2'($urandom_range(0, 3)), $urandom_range(1, 8), sent);
			end else if (pick < 18) begin
				put_word(ACT_SCORE, ($urandom_range(0, 15) == 0) ? KIND_NONE
					: 2'($urandom_range(0, 2)), $urandom_range(1, 8), sent);
			end else begin
				// noise: any action, kind, byte and end flag
				put_byte(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
				sent++;
			end
			// a long idle stretch every so often
			if ($urandom_range(0, 30) == 0) pause($urandom_range(20, 60));
		end
	endtask

	initial begin
		logic [63:0] r0, r1, r2;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: simple pair, case variants, breaks and transparent bytes
		put_byte(ACT_ADD, KIND_NICK, "a", 0);
		put_byte(ACT_ADD, KIND_NICK, "b", 1);
		put_byte(ACT_ADD, KIND_USER, "A", 0);
		put_byte(ACT_ADD, KIND_USER, 8'h00, 0);   // control byte is transparent
		put_byte(ACT_ADD, KIND_USER, "b", 0);
		put_byte(ACT_ADD, KIND_USER, 8'hFF, 0);   // high byte breaks the pair
		put_byte(ACT_ADD, KIND_USER, 8'h20, 0);
		put_byte(ACT_ADD, KIND_USER, 8'h7E, 1);
		put_byte(ACT_REMOVE, KIND_NICK, "z", 0);  // remove below zero holds at zero
		put_byte(ACT_REMOVE, KIND_NICK, "q", 1);
		put_byte(ACT_SCORE, KIND_NICK, "a", 0);   // folded score sums case forms
		put_byte(ACT_SCORE, KIND_NICK, "B", 1);
		put_byte(ACT_SCORE, KIND_INFO, "x", 1);   // single byte, no pair
		put_byte(ACT_SCORE, KIND_NONE, "a", 0);   // kind with an empty set
		put_byte(ACT_SCORE, KIND_NONE, "b", 1);
		put_byte(ACT_NONE, KIND_NICK, "a", 0);    // undefined action touches nothing
		put_byte(ACT_ADD, KIND_NICK, 8'h7F, 1);
		put_byte(ACT_SCORE, KIND_USER, "A", 0);
		put_byte(ACT_SCORE, KIND_USER, "-", 0);   // outside set, skipped in skip mode
		put_byte(ACT_SCORE, KIND_USER, "b", 1);
		put_byte(ACT_ADD, KIND_NICK, "a", 0);     // mixed actions share the previous byte
		put_byte(ACT_SCORE, KIND_NICK, "b", 1);
		pause(1);
		random_phase(250);

		// extremes: everything in every set, adjacent mode, no folding
		load_all('1, '1, '1, '1, '1, '1, 6'h38);
		random_phase(250);
		// empty sets, all bits of mode set
		load_all('0, '0, '0, '0, '0, '0, 6'h3F);
		random_phase(100);
		// mixed adjacent and skip, folding off
		load_all(ALNUM_LOW_RST, ALPHA_HIGH_RST, '1, '1, ALPHA_LOW_RST, ALPHA_HIGH_RST, 6'h28);
		random_phase(350);
		// random sets and modes
		for (int p = 0; p < 3; p++) begin
			r0 = {$urandom, $urandom};
			r1 = {$urandom, $urandom};
			r2 = {$urandom, $urandom};
			load_all(r0 | ALNUM_LOW_RST, 31'($urandom), r1, 31'($urandom) | ALPHA_HIGH_RST,
				r2, 31'($urandom), 6'($urandom));
			random_phase(230);
		end

		drain();
		$display("sent %0d byte beats, checked %0d means over %0d register settings",
			beats_seen, means_seen, phases_run + 1);
		if (fail_count == 0) begin
			$display("** char_bigram_count_and_score_unit: PASSED **");
		end else begin
			$display("** char_bigram_count_and_score_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_front.sv
rtl/cbs_queue.sv
rtl/cbs_back.sv
rtl/char_bigram_count_and_score_unit.sv
bench/char_bigram_count_and_score_unit_check.sv
bench/char_bigram_count_and_score_unit_test.sv
